// ===== rtl/periodic_timer_table_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Periodic timer table: assertion macros
// Shared concurrent check wrappers, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_TABLE_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define PTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ptt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic timer table package
// Operation and result codes and the packed layout of one table entry.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] K_DONE = 2'd0;
    localparam logic [1:0] K_FIRE = 2'd1;
    localparam logic [1:0] K_FULL = 2'd2;
    localparam logic [1:0] K_ZERO = 2'd3;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] period;
        logic [31:0] last_run;
        logic [31:0] value;
    } t_entry;

endpackage

// ===== rtl/ptt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/periodic_timer_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic timer table
// Insertion-ordered table of periodic timers with add, delete and tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command beat: add,
//   delete or tick. Output channel (o_out_valid / i_out_stall) returns result
//   beats; o_last marks the final beat of a command.
//   Add: one result beat, loaded from S_FIN once the output register is free.
//   Delete: S_DRD skips pending slots and S_DCMP compares each active slot
//   until a match, which is marked, or the end of the table; then the done beat.
//   Tick: one pass over the table that compacts out deleted slots and tests
//   each live timer; a live slot passes S_TRD and S_TEV, a deleted slot only
//   S_TRD, then the done beat. The pass is bound by the single entry RAM
//   read port and the one shared subtract/compare.
//   One command is in flight at a time; o_in_stall is high until its last
//   beat is loaded into the output register, which may still be waiting, so
//   the next command can be taken in the cycle after that.
//   A stalled output holds its beat and the sequencer waits before loading
//   the next one.
//   Reset empties the table at once (count and flag bits clear); the entry
//   RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`include "periodic_timer_table_unit_defines.svh"

module periodic_timer_table_unit #(
    parameter int SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic [15:0]        i_timer_id,
    input  logic [31:0]        i_period,
    input  logic signed [31:0] i_user_value,
    input  logic [31:0]        i_now,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_kind,
    output logic [15:0]        o_fired_id,
    output logic signed [31:0] o_fired_value,
    output logic               o_last
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = $bits(ptt_pkg::t_entry);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DRD  = 6'b000010,
        S_DCMP = 6'b000100,
        S_TRD  = 6'b001000,
        S_TEV  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_wptr, n_wptr;
    logic [15:0]        r_id, n_id;
    logic [31:0]        r_now, n_now;
    logic [1:0]         r_kind, n_kind;
    logic [SLOTS-1:0]   r_marked, n_marked;
    logic [SLOTS-1:0]   r_pending, n_pending;

    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_out_kind, n_out_kind;
    logic [15:0]        r_out_id, n_out_id;
    logic signed [31:0] r_out_value, n_out_value;
    logic               r_out_last, n_out_last;

    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    ptt_pkg::t_entry    w_wr_entry;
    logic [EW-1:0]      w_rd_data;
    ptt_pkg::t_entry    w_rd_entry;
    logic               w_can_load;
    logic               w_fire;
    logic               w_in_acc;
    logic [SLOTS-1:0]   w_live_mask;

    ptt_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_entry),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_entry = ptt_pkg::t_entry'(w_rd_data);
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_can_load = !r_out_valid || !i_out_stall;
    // wrapping elapsed time against the period
    assign w_fire     = (r_now - w_rd_entry.last_run) >= w_rd_entry.period;

    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            w_live_mask[k] = (CW'(k) < r_count);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_wptr      = r_wptr;
        n_id        = r_id;
        n_now       = r_now;
        n_kind      = r_kind;
        n_marked    = r_marked;
        n_pending   = r_pending;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_id    = r_out_id;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;

        w_wr_en             = 1'b0;
        w_wr_addr           = r_count[AW-1:0];
        w_wr_entry.id       = i_timer_id;
        w_wr_entry.period   = i_period;
        w_wr_entry.last_run = i_now;
        w_wr_entry.value    = $unsigned(i_user_value);

        // beat taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_id   = i_timer_id;
                    n_now  = i_now;
                    n_idx  = '0;
                    n_wptr = '0;
                    n_kind = ptt_pkg::K_DONE;
                    case (i_operation)
                        ptt_pkg::OP_ADD: begin
                            n_state = S_FIN;
                            if (i_period == 32'd0) begin
                                n_kind = ptt_pkg::K_ZERO;
                            end else if (r_count >= CW'(SLOTS)) begin
                                n_kind = ptt_pkg::K_FULL;
                            end else begin
                                w_wr_en                      = 1'b1;
                                n_pending[r_count[AW-1:0]]   = 1'b1;
                                n_marked[r_count[AW-1:0]]    = 1'b0;
                                n_count                      = r_count + CW'(1);
                            end
                        end
                        ptt_pkg::OP_DEL: begin
                            n_state = S_DRD;
                        end
                        ptt_pkg::OP_TICK: begin
                            n_pending = '0;
                            n_state   = S_TRD;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_DRD: begin
                if (r_idx == r_count) begin
                    n_state = S_FIN;
                end else if (r_pending[r_idx[AW-1:0]]) begin
                    n_idx = r_idx + CW'(1);
                end else begin
                    n_state = S_DCMP;
                end
            end
            S_DCMP: begin
                if (w_rd_entry.id == r_id) begin
                    n_marked[r_idx[AW-1:0]] = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_DRD;
                end
            end
            S_TRD: begin
                if (r_idx == r_count) begin
                    // compaction done: survivors sit in slots below the write pointer
                    n_count  = r_wptr;
                    n_marked = '0;
                    n_state  = S_FIN;
                end else if (r_marked[r_idx[AW-1:0]]) begin
                    n_idx = r_idx + CW'(1);
                end else begin
                    n_state = S_TEV;
                end
            end
            S_TEV: begin
                if (!w_fire || w_can_load) begin
                    w_wr_en    = 1'b1;
                    w_wr_addr  = r_wptr[AW-1:0];
                    w_wr_entry = w_rd_entry;
                    if (w_fire) begin
                        w_wr_entry.last_run = r_now;
                        n_out_valid = 1'b1;
                        n_out_kind  = ptt_pkg::K_FIRE;
                        n_out_id    = w_rd_entry.id;
                        n_out_value = signed'(w_rd_entry.value);
                        n_out_last  = 1'b0;
                    end
                    n_wptr  = r_wptr + CW'(1);
                    n_idx   = r_idx + CW'(1);
                    n_state = S_TRD;
                end
            end
            S_FIN: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_kind;
                    n_out_id    = 16'd0;
                    n_out_value = 32'sd0;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_marked    <= '0;
            r_pending   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_marked    <= n_marked;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_wptr      <= n_wptr;
        r_id        <= n_id;
        r_now       <= n_now;
        r_kind      <= n_kind;
        r_out_kind  <= n_out_kind;
        r_out_id    <= n_out_id;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_fired_id    = r_out_id;
    assign o_fired_value = r_out_value;
    assign o_last        = r_out_last;

    `PTT_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(SLOTS),
        "entry count beyond table size")
    `PTT_ASSERT_NOW(a_flags_live, i_clk, i_rst_n, r_state == S_IDLE,
        ((r_marked | r_pending) & ~w_live_mask) == '0,
        "flag set on a slot beyond the entry count")
    `PTT_ASSERT_NOW(a_compact_order, i_clk, i_rst_n, r_state == S_TEV,
        (r_wptr <= r_idx) && (r_idx < r_count),
        "compaction write pointer ahead of read index")
    `PTT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc,
        r_state != S_IDLE, "sequencer idle straight after accepting a beat")

endmodule

// ===== sim/tb_periodic_timer_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic timer table testbench
// Feeds add, delete, tick and unused-code beats with random gaps and output stalls, keeps
// its own copy of the timer table and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_periodic_timer_table_unit;

    localparam int         NSLOT          = 16;
    localparam logic [1:0] OP_SPARE       = 2'd3;  // unused code, answered with done
    localparam int         IDLE_PCT       = 37;
    localparam int         CALM_FROM      = 120;   // no gaps or stalls in this stretch
    localparam int         CALM_TO        = 175;
    localparam int         RANDOM_CMDS    = 202;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         TAIL_CYCLES    = 80;

    typedef struct {
        logic [1:0]         op;
        logic [15:0]        id;
        logic [31:0]        period;
        logic signed [31:0] value;
        logic [31:0]        now;
    } t_cmd;

    typedef struct {
        logic [1:0]         kind;
        logic [15:0]        id;
        logic signed [31:0] value;
        logic               is_last;
    } t_result;

    typedef struct {
        logic [15:0]        id;
        logic [31:0]        period;
        logic [31:0]        last_run;
        logic signed [31:0] value;
        bit                 marked;
        bit                 pending;
    } t_timer;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_operation;
    logic [15:0]        i_timer_id;
    logic [31:0]        i_period;
    logic signed [31:0] i_user_value;
    logic [31:0]        i_now;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_kind;
    logic [15:0]        o_fired_id;
    logic signed [31:0] o_fired_value;
    logic               o_last;

    periodic_timer_table_unit #(.SLOTS(NSLOT)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_timer_id    (i_timer_id),
        .i_period      (i_period),
        .i_user_value  (i_user_value),
        .i_now         (i_now),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_fired_id    (o_fired_id),
        .o_fired_value (o_fired_value),
        .o_last        (o_last)
    );

    always #4 i_clk = ~i_clk;

    // model of the timer table and the beats it still owes
    t_timer  timers[NSLOT];
    int      live_count = 0;
    t_result owed_results[$];
    t_cmd    cmd_backlog[$];

    int  total_cmds     = 0;
    int  cmds_sent      = 0;
    int  cmds_accepted  = 0;
    int  beats_checked  = 0;
    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    int  tick_count     = 0;
    int  fire_count     = 0;
    int  full_count     = 0;
    int  zero_count     = 0;
    int  widest_tick    = 0;
    bit  cmd_taken      = 1'b0;
    bit  calm           = 1'b0;

    logic [31:0] now_ms;
    logic [15:0] id_pool[6];

    function automatic void owe_result(logic [1:0] kind, logic [15:0] id,
                                       logic signed [31:0] value, logic is_last);
        t_result r;
        r.kind    = kind;
        r.id      = id;
        r.value   = value;
        r.is_last = is_last;
        owed_results.insert(owed_results.size(), r);
    endfunction

    function automatic void advance_timer_table(t_cmd c);
        int          i;
        int          w;
        int          nfire;
        logic [31:0] elapsed;
        nfire = 0;
        case (c.op)
            ptt_pkg::OP_ADD: begin
                if (c.period == 32'd0) begin
                    zero_count++;
                    owe_result(ptt_pkg::K_ZERO, 16'd0, 32'sd0, 1'b1);
                end else if (live_count >= NSLOT) begin
                    full_count++;
                    owe_result(ptt_pkg::K_FULL, 16'd0, 32'sd0, 1'b1);
                end else begin
                    timers[live_count] = '{c.id, c.period, c.now, c.value, 1'b0, 1'b1};
                    live_count++;
                    owe_result(ptt_pkg::K_DONE, 16'd0, 32'sd0, 1'b1);
                end
            end
            ptt_pkg::OP_DEL: begin
                // first active match only; an already marked entry still counts
                for (i = 0; i < live_count; i++) begin
                    if (!timers[i].pending && timers[i].id == c.id) begin
                        timers[i].marked = 1'b1;
                        break;
                    end
                end
                owe_result(ptt_pkg::K_DONE, 16'd0, 32'sd0, 1'b1);
            end
            ptt_pkg::OP_TICK: begin
                tick_count++;
                for (i = 0; i < live_count; i++)
                    timers[i].pending = 1'b0;
                w = 0;
                for (i = 0; i < live_count; i++) begin
                    if (!timers[i].marked) begin
                        timers[w] = timers[i];
                        w++;
                    end
                end
                live_count = w;
                for (i = 0; i < live_count; i++) begin
                    elapsed = c.now - timers[i].last_run;
                    if (elapsed >= timers[i].period) begin
                        timers[i].last_run = c.now;
                        owe_result(ptt_pkg::K_FIRE, timers[i].id, timers[i].value, 1'b0);
                        nfire++;
                    end
                end
                fire_count += nfire;
                if (nfire > widest_tick)
                    widest_tick = nfire;
                owe_result(ptt_pkg::K_DONE, 16'd0, 32'sd0, 1'b1);
            end
            default: begin
                owe_result(ptt_pkg::K_DONE, 16'd0, 32'sd0, 1'b1);
            end
        endcase
    endfunction

    function automatic void queue_cmd(logic [1:0] op, logic [15:0] id, logic [31:0] period,
                                      logic signed [31:0] value, logic [31:0] now);
        t_cmd c;
        c.op     = op;
        c.id     = id;
        c.period = period;
        c.value  = value;
        c.now    = now;
        cmd_backlog.insert(cmd_backlog.size(), c);
    endfunction

    function automatic logic [15:0] pick_id();
        if ($urandom_range(0, 99) < 85)
            return id_pool[$urandom_range(0, 5)];
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 12);
        if (r < 92)
            return $urandom_range(13, 200);
        if (r < 97)
            return $urandom_range(1, 32'hFFFF_FFFF);
        return 32'hFFFF_FFFF;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // driver: new beats and output stalls change on the falling edge
    always @(negedge i_clk) begin
        t_cmd c;
        if (i_rst_n) begin
            calm = (cmds_sent >= CALM_FROM) && (cmds_sent < CALM_TO);
            i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            if (!i_in_valid || cmd_taken) begin
                cmd_taken = 1'b0;
                if (cmd_backlog.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    c = cmd_backlog.pop_front();
                    i_operation  <= c.op;
                    i_timer_id   <= c.id;
                    i_period     <= c.period;
                    i_user_value <= c.value;
                    i_now        <= c.now;
                    i_in_valid   <= 1'b1;
                    cmds_sent++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: accepted beats on both channels, plus the no-progress watchdog
    always @(posedge i_clk) begin
        t_cmd    c;
        t_result want;
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_in_valid && !o_in_stall) begin
                c = '{i_operation, i_timer_id, i_period, i_user_value, i_now};
                advance_timer_table(c);
                cmd_taken = 1'b1;
                cmds_accepted++;
                quiet_cycles = 0;
            end
            if (o_out_valid && !i_out_stall) begin
                quiet_cycles = 0;
                beats_checked++;
                if (owed_results.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing owed: kind %0d id %h",
                                              o_kind, o_fired_id));
                end else begin
                    want = owed_results.pop_front();
                    if (o_kind !== want.kind || o_fired_id !== want.id ||
                        o_fired_value !== want.value || o_last !== want.is_last)
                        report_mismatch($sformatf(
                            "got kind %0d id %h val %h last %b, want %0d %h %h %b",
                            o_kind, o_fired_id, o_fired_value, o_last,
                            want.kind, want.id, want.value, want.is_last));
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int k;
        int r;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_out_stall  = 1'b0;
        i_operation  = ptt_pkg::OP_ADD;
        i_timer_id   = 16'd0;
        i_period     = 32'd0;
        i_user_value = 32'sd0;
        i_now        = 32'd0;

        for (k = 0; k < 6; k++)
            id_pool[k] = 16'($urandom);

        // directed: empty table, odd codes, wrap-around at both ends of now and period
        queue_cmd(ptt_pkg::OP_TICK, 16'd0, 32'd0, 32'sd0, 32'd0);
        queue_cmd(ptt_pkg::OP_DEL, 16'h1234, 32'd0, 32'sd0, 32'd0);
        queue_cmd(ptt_pkg::OP_ADD, 16'h5555, 32'd0, 32'sd5, 32'd0);
        queue_cmd(OP_SPARE, 16'hA5A5, 32'h1234_5678, 32'sd1, 32'd9);
        queue_cmd(ptt_pkg::OP_ADD, 16'hFFFF, 32'd1, 32'sh7FFF_FFFF, 32'hFFFF_FFFE);
        queue_cmd(ptt_pkg::OP_ADD, 16'h0000, 32'hFFFF_FFFF, 32'sh8000_0000, 32'd0);
        queue_cmd(ptt_pkg::OP_DEL, 16'hFFFF, 32'd0, 32'sd0, 32'd0);        // still pending
        queue_cmd(ptt_pkg::OP_TICK, 16'd0, 32'd0, 32'sd0, 32'hFFFF_FFFF);
        queue_cmd(ptt_pkg::OP_DEL, 16'hFFFF, 32'd0, 32'sd0, 32'd0);
        queue_cmd(ptt_pkg::OP_DEL, 16'hFFFF, 32'd0, 32'sd0, 32'd0);        // re-mark, no change
        queue_cmd(ptt_pkg::OP_TICK, 16'd0, 32'd0, 32'sd0, 32'd0);
        for (k = 0; k < NSLOT - 1; k++)
            queue_cmd(ptt_pkg::OP_ADD, 16'(16'h0100 + k), 32'd1, $urandom, 32'd0);
        queue_cmd(ptt_pkg::OP_ADD, 16'h0200, 32'd7, 32'sd7, 32'd0);        // table full
        queue_cmd(ptt_pkg::OP_TICK, 16'd0, 32'd0, 32'sd0, 32'hFFFF_FFFE);  // every slot fires

        // random: mostly sensible traffic, clock runs over the 32-bit wrap
        now_ms = 32'hFFFF_FF60;
        for (k = 0; k < RANDOM_CMDS; k++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                queue_cmd(ptt_pkg::OP_ADD, pick_id(), pick_period(), $urandom, now_ms);
            end else if (r < 55) begin
                queue_cmd(ptt_pkg::OP_DEL, pick_id(), $urandom, $urandom, $urandom);
            end else if (r < 95) begin
                if ($urandom_range(0, 29) == 0)
                    now_ms = $urandom;
                else
                    now_ms = now_ms + $urandom_range(0, 9);
                queue_cmd(ptt_pkg::OP_TICK, 16'($urandom), $urandom, $urandom, now_ms);
            end else if (r < 98) begin
                queue_cmd(ptt_pkg::OP_ADD, pick_id(), 32'd0, $urandom, now_ms);
            end else begin
                queue_cmd(OP_SPARE, 16'($urandom), $urandom, $urandom, now_ms);
            end
        end
        total_cmds = cmd_backlog.size();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_accepted < total_cmds || owed_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("ran %0d commands with %0d ticks; %0d firings, up to %0d in one tick",
                 cmds_accepted, tick_count, fire_count, widest_tick);
        $display("%0d full-table rejects, %0d zero-period adds, %0d beats checked",
                 full_count, zero_count, beats_checked);
        if (mismatch_count == 0 && owed_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
